[hw/rtl/tss_pkg.sv]
package tss_pkg;

    // Widths of the header arithmetic.
    localparam int HLEN_W = 7;   // 4 * (15 + 15) = 120 fits in 7 bits
    localparam int LEN_W  = 16;
    localparam int SLEN_W = 17;  // signed payload length and room
    localparam int SEQ_W  = 32;
    localparam int CNT_W  = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MTU      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_HINT = 1'b1;

    // Header figures of one packet, worked out once at the start.
    typedef struct packed {
        logic                     mtu_zero;
        logic [HLEN_W-1:0]        hlen;
        logic signed [SLEN_W-1:0] plen;
        logic signed [SLEN_W-1:0] room;
    } prep_t;

    // One step of the segment walk.
    typedef struct packed {
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  ip_len;
        logic [LEN_W-1:0]  rem_next;
        logic [LEN_W-1:0]  off_next;
    } seg_step_t;

endpackage

[hw/rtl/tss_prep.sv]
module tss_prep
    import tss_pkg::*;
(
    input  logic [LEN_W-1:0] mtu,
    input  logic             use_mtu_hint,
    input  logic [3:0]       ip_header_words,
    input  logic [3:0]       tcp_header_words,
    input  logic [LEN_W-1:0] ip_total_length,
    input  logic [LEN_W-1:0] mtu_hint,
    output prep_t            prep
);

    logic [LEN_W-1:0]  eff_mtu;
    logic [4:0]        words;
    logic [HLEN_W-1:0] hlen;

    // A nonzero hint wins when enabled and smaller than the MTU, or when no MTU is set.
    always_comb begin
        eff_mtu = mtu;
        if (use_mtu_hint && (mtu_hint != '0) && ((mtu == '0) || (mtu > mtu_hint))) begin
            eff_mtu = mtu_hint;
        end
    end

    // Header length in bytes, then payload length and room per segment.
    assign words = {1'b0, ip_header_words} + {1'b0, tcp_header_words};
    assign hlen  = {words, 2'b00};

    assign prep.mtu_zero = (eff_mtu == '0);
    assign prep.hlen     = hlen;
    assign prep.plen     = $signed({1'b0, ip_total_length})
                         - $signed({{(SLEN_W-HLEN_W){1'b0}}, hlen});
    assign prep.room     = $signed({1'b0, eff_mtu})
                         - $signed({{(SLEN_W-HLEN_W){1'b0}}, hlen});

endmodule

[hw/rtl/tss_step.sv]
module tss_step
    import tss_pkg::*;
(
    input  logic [LEN_W-1:0]  rem,
    input  logic [LEN_W-1:0]  off,
    input  logic [LEN_W-1:0]  room,
    input  logic [HLEN_W-1:0] hlen,
    output seg_step_t         step
);

    logic last;
    logic [LEN_W-1:0] len;

    // The final segment takes whatever payload is left; the others take a full room.
    assign last = (rem <= room);
    assign len  = last ? rem : room;

    assign step.last     = last;
    assign step.len      = len;
    assign step.ip_len   = len + {{(LEN_W-HLEN_W){1'b0}}, hlen};
    assign step.rem_next = rem - room;
    assign step.off_next = off + room;

endmodule

[hw/rtl/tcp_segment_splitter_unit.sv]
// Cuts one TCP/IP header description into segment words that fit the effective
// MTU (the configured mtu, or a smaller nonzero per-packet hint when use_mtu_hint
// is set). A packet whose payload is smaller than the room per segment, or that
// has no MTU or no room, gives one word with pass_whole set; one that would need
// more than MAX_SEGMENTS segments gives one word with too_many_segments set. An
// input word is taken in the idle state, followed by a step to work out the header
// figures and a step to check for a whole pass; a packet that is not passed whole
// spends one more step on the segment-count limit, and a split packet then
// produces one segment word per cycle while the result side does not stall, from
// a single shared add/compare step. The block takes a new word as soon as the
// last result of the previous one sits in the output register.
module tcp_segment_splitter_unit
    import tss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
)(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_ip_header_words,
    input  logic [3:0]           s_tcp_header_words,
    input  logic [LEN_W-1:0]     s_ip_total_length,
    input  logic [SEQ_W-1:0]     s_sequence_number,
    input  logic                 s_fin_flag,
    input  logic [LEN_W-1:0]     s_mtu_hint,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_pass_whole,
    output logic [LEN_W-1:0]     m_payload_offset,
    output logic [LEN_W-1:0]     m_payload_length,
    output logic [LEN_W-1:0]     m_segment_ip_length,
    output logic [SEQ_W-1:0]     m_segment_sequence,
    output logic                 m_segment_fin,
    output logic                 m_too_many_segments,
    output logic                 m_last_of_run
);

    localparam int LIMIT_W = LEN_W + $clog2(MAX_SEGMENTS + 1);
    localparam logic [LIMIT_W-1:0] MAX_SEG_L = LIMIT_W'(MAX_SEGMENTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_SEG   = 3'd4;

    // Configuration registers.
    logic [LEN_W-1:0] mtu_reg;
    logic             use_hint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg      <= '0;
            use_hint_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MTU:      mtu_reg      <= cfg_wdata;
                CFG_USE_HINT: use_hint_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    logic [2:0]         state_reg, state_next;
    logic [3:0]         ipw_reg;
    logic [3:0]         tcpw_reg;
    logic [LEN_W-1:0]   total_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic               fin_reg;
    logic [LEN_W-1:0]   hint_reg;
    prep_t              prep_reg;
    prep_t              prep_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LEN_W-1:0]   off_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   packets_seen_reg;
    logic [CNT_W-1:0]   packets_split_reg;
    logic [CNT_W-1:0]   segments_made_reg;

    // Output register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_whole_reg;
    logic [LEN_W-1:0] out_off_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [LEN_W-1:0] out_iplen_reg;
    logic [SEQ_W-1:0] out_seq_reg;
    logic             out_fin_reg;
    logic             out_many_reg;
    logic             out_last_reg;

    logic                     in_accept;
    logic                     out_free;
    logic signed [SLEN_W-1:0] plen_s;
    logic signed [SLEN_W-1:0] room_s;
    logic                     whole_cond;
    logic [LEN_W-1:0]         plen_u;
    logic [LEN_W-1:0]         room_u;
    logic [LEN_W-1:0]         plen_clip;
    logic                     over_limit;
    seg_step_t                step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    tss_prep u_prep (
        .mtu              (mtu_reg),
        .use_mtu_hint     (use_hint_reg),
        .ip_header_words  (ipw_reg),
        .tcp_header_words (tcpw_reg),
        .ip_total_length  (total_reg),
        .mtu_hint         (hint_reg),
        .prep             (prep_next)
    );

    // Decisions on the registered header figures.
    assign plen_s     = prep_reg.plen;
    assign room_s     = prep_reg.room;
    assign whole_cond = prep_reg.mtu_zero || (room_s <= 0) || (plen_s < room_s);
    assign plen_u     = plen_s[LEN_W-1:0];
    assign room_u     = room_s[LEN_W-1:0];
    assign plen_clip  = (plen_s > 0) ? plen_u : '0;
    assign over_limit = ({{(LIMIT_W-LEN_W){1'b0}}, plen_u} > limit_reg);

    tss_step u_step (
        .rem  (rem_reg),
        .off  (off_reg),
        .room (room_u),
        .hlen (prep_reg.hlen),
        .step (step)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!whole_cond)   state_next = ST_LIMIT;
                else if (out_free) state_next = ST_IDLE;
            end
            ST_LIMIT: begin
                if (!over_limit)   state_next = ST_SEG;
                else if (out_free) state_next = ST_IDLE;
            end
            ST_SEG: begin
                if (out_free && step.last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The output word is held until taken; a new one loads only into a free register.
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_CHECK: begin
                if (whole_cond && out_free) out_valid_next = 1'b1;
            end
            ST_LIMIT: begin
                if (over_limit && out_free) out_valid_next = 1'b1;
            end
            ST_SEG: begin
                if (out_free) out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            packets_seen_reg  <= '0;
            packets_split_reg <= '0;
            segments_made_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_accept) begin
                packets_seen_reg <= packets_seen_reg + CNT_W'(1);
            end
            case (state_reg)
                ST_LIMIT: begin
                    if (!over_limit) begin
                        packets_split_reg <= packets_split_reg + CNT_W'(1);
                    end
                end
                ST_SEG: begin
                    if (out_free) begin
                        segments_made_reg <= segments_made_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: input capture, header figures, segment walk and result word.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ipw_reg   <= s_ip_header_words;
            tcpw_reg  <= s_tcp_header_words;
            total_reg <= s_ip_total_length;
            seq_reg   <= s_sequence_number;
            fin_reg   <= s_fin_flag;
            hint_reg  <= s_mtu_hint;
        end
        case (state_reg)
            ST_PREP: begin
                prep_reg <= prep_next;
            end
            ST_CHECK: begin
                limit_reg <= LIMIT_W'(room_u) * MAX_SEG_L;
                if (out_free) begin
                    out_whole_reg <= 1'b1;
                    out_many_reg  <= 1'b0;
                end
                if (out_free) begin
                    out_off_reg   <= '0;
                    out_len_reg   <= plen_clip;
                    out_iplen_reg <= total_reg;
                    out_seq_reg   <= seq_reg;
                    out_fin_reg   <= fin_reg;
                    out_last_reg  <= 1'b1;
                end
            end
            ST_LIMIT: begin
                off_reg <= '0;
                rem_reg <= plen_u;
                if (over_limit && out_free) begin
                    out_whole_reg <= 1'b0;
                    out_many_reg  <= 1'b1;
                    out_off_reg   <= '0;
                    out_len_reg   <= plen_clip;
                    out_iplen_reg <= total_reg;
                    out_seq_reg   <= seq_reg;
                    out_fin_reg   <= fin_reg;
                    out_last_reg  <= 1'b1;
                end
            end
            ST_SEG: begin
                if (out_free) begin
                    off_reg       <= step.off_next;
                    rem_reg       <= step.rem_next;
                    out_whole_reg <= 1'b0;
                    out_many_reg  <= 1'b0;
                    out_off_reg   <= off_reg;
                    out_len_reg   <= step.len;
                    out_iplen_reg <= step.ip_len;
                    out_seq_reg   <= seq_reg + {{(SEQ_W-LEN_W){1'b0}}, off_reg};
                    out_fin_reg   <= step.last && fin_reg;
                    out_last_reg  <= step.last;
                end
            end
            default: ;
        endcase
    end

    assign m_valid             = out_valid_reg;
    assign m_pass_whole        = out_whole_reg;
    assign m_payload_offset    = out_off_reg;
    assign m_payload_length    = out_len_reg;
    assign m_segment_ip_length = out_iplen_reg;
    assign m_segment_sequence  = out_seq_reg;
    assign m_segment_fin       = out_fin_reg;
    assign m_too_many_segments = out_many_reg;
    assign m_last_of_run       = out_last_reg;

endmodule
